// File: design/crcfr_pkg.sv
package crcfr_pkg;

    // Frame layout and protocol constants
    localparam logic [7:0]  SYNC_RESET     = 8'h3D;
    localparam logic [7:0]  CRC8_POLY      = 8'h39;
    localparam logic [7:0]  CRC8_INIT      = 8'h66;
    localparam logic [15:0] CRC16_POLY     = 16'h1021;
    localparam logic [15:0] CRC16_INIT     = 16'h913D;
    localparam logic [7:0]  CMD_STATUS     = 8'h80;
    localparam logic [7:0]  ST_ONLINE_WAIT = 8'hF1;
    localparam logic [7:0]  ST_ONLINE      = 8'hF0;
    localparam logic [7:0]  ST_OFFLINE     = 8'h0F;
    localparam logic [7:0]  MIN_FRAME      = 8'd7;
    localparam int          MASK_SLOTS     = 16;

    // Byte positions within a frame
    localparam logic [7:0] POS_HUNT = 8'd0;
    localparam logic [7:0] POS_ADDR = 8'd1;
    localparam logic [7:0] POS_LEN  = 8'd3;
    localparam logic [7:0] POS_HCRC = 8'd4;
    localparam logic [7:0] POS_CMD  = 8'd5;
    localparam logic [7:0] POS_STAT = 8'd6;

    // Parameter defaults
    localparam int MAX_FRAME_DEF  = 128;
    localparam int NUM_SLOTS_DEF  = 16;
    localparam int FIFO_DEPTH_DEF = 2;

    typedef enum logic [1:0] {
        VERDICT_OK      = 2'd0,
        VERDICT_CRC_BAD = 2'd1,
        VERDICT_RANGE   = 2'd2,
        VERDICT_SHORT   = 2'd3
    } t_verdict;

    // Completed frame, handed from front to back
    typedef struct packed {
        logic [7:0] addr;
        logic [7:0] cmd;
        logic [7:0] status;
        logic [7:0] len;
        logic       crc_ok;
        logic       short_frame;
    } t_event;

    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            c = c[7] ? ((c << 1) ^ CRC8_POLY) : (c << 1);
        end
        return c;
    endfunction

    function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = c[15] ? ((c << 1) ^ CRC16_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

// File: design/crcfr_if.sv
interface crcfr_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface crcfr_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] sync_byte;
    modport source (output valid, output sync_byte, input ready);
    modport sink   (input valid, input sync_byte, output ready);
endinterface

interface crcfr_res_if;
    logic        valid;
    logic        ready;
    logic [7:0]  slot_address;
    logic [7:0]  command_code;
    logic [7:0]  status_code;
    logic [7:0]  frame_length;
    logic [1:0]  verdict;
    logic [15:0] online_mask;
    logic [15:0] waiting_mask;
    modport source (output valid, output slot_address, output command_code,
                    output status_code, output frame_length, output verdict,
                    output online_mask, output waiting_mask, input ready);
    modport sink   (input valid, input slot_address, input command_code,
                    input status_code, input frame_length, input verdict,
                    input online_mask, input waiting_mask, output ready);
    modport mon    (input valid, input slot_address, input command_code,
                    input status_code, input frame_length, input verdict,
                    input online_mask, input waiting_mask, input ready);
endinterface

// File: design/crc_checked_frame_receiver.sv
// Channel  | Dir | Handshake     | Word
// ---------+-----+---------------+------------------------------------------
// i_rx     | in  | valid/ready   | rx_byte, one received serial byte
// i_cfg    | in  | valid/ready   | sync_byte, frame start value (reset 0x3D)
// o_res    | out | valid/ready   | frame verdict, captured fields, slot masks
//
// One byte per cycle sustained while the event queue is not full. The front
// parser steps CRC8 over the header and CRC16 over the frame up to the trailer.
// Verdicts reach o_res via the event queue, then the back-end output register.
// Synchronous active-low reset: hunting for sync, queue empty, masks cleared.
// i_rx.ready drops only while the event queue is full, i.e. the back end
// is held by o_res.ready for several frames in a row.
module crc_checked_frame_receiver #(
    parameter int MAX_FRAME  = crcfr_pkg::MAX_FRAME_DEF,
    parameter int NUM_SLOTS  = crcfr_pkg::NUM_SLOTS_DEF,
    parameter int FIFO_DEPTH = crcfr_pkg::FIFO_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    crcfr_byte_if.sink  i_rx,
    crcfr_cfg_if.sink   i_cfg,
    crcfr_res_if.source o_res
);
    import crcfr_pkg::*;

    // front -> queue
    logic   push;
    t_event push_event;
    logic   full;

    // queue -> back
    logic   pend_valid;
    t_event pend_event;
    logic   pop;

    // Front: sync hunt, header CRC8 check, length filter, trailer CRC16
    crcfr_front #(
        .MAX_FRAME (MAX_FRAME)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (i_rx),
        .i_cfg   (i_cfg),
        .i_full  (full),
        .o_push  (push),
        .o_event (push_event)
    );

    // Completed-frame queue decouples parsing from result delivery
    crcfr_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_event (push_event),
        .i_pop   (pop),
        .o_full  (full),
        .o_valid (pend_valid),
        .o_event (pend_event)
    );

    // Back: verdict, slot mask update, output register
    crcfr_back #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (pend_valid),
        .i_event (pend_event),
        .o_pop   (pop),
        .o_res   (o_res)
    );

endmodule

// File: design/crcfr_front.sv
module crcfr_front #(
    parameter int MAX_FRAME = crcfr_pkg::MAX_FRAME_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    crcfr_byte_if.sink        i_rx,
    crcfr_cfg_if.sink         i_cfg,
    input  logic              i_full,
    output logic              o_push,
    output crcfr_pkg::t_event o_event
);
    import crcfr_pkg::*;

    logic [7:0]  r_sync, n_sync;
    logic [7:0]  r_pos, n_pos;
    logic [7:0]  r_len, n_len;
    logic [7:0]  r_hcrc, n_hcrc;
    logic [15:0] r_tcrc, n_tcrc;
    logic        r_low_ok, n_low_ok;
    logic [7:0]  r_addr, n_addr;
    logic [7:0]  r_cmd, n_cmd;
    logic [7:0]  r_status, n_status;

    logic        accept;
    logic [7:0]  b;
    logic        hit_low;
    logic        hit_last;

    assign i_rx.ready  = !i_full;
    assign i_cfg.ready = 1'b1;
    assign accept      = i_rx.valid && !i_full;
    assign b           = i_rx.rx_byte;
    assign hit_low     = ({1'b0, r_pos} + 9'd2) == {1'b0, r_len};
    assign hit_last    = ({1'b0, r_pos} + 9'd1) == {1'b0, r_len};

    always_comb begin
        n_sync   = r_sync;
        n_pos    = r_pos;
        n_len    = r_len;
        n_hcrc   = r_hcrc;
        n_tcrc   = r_tcrc;
        n_low_ok = r_low_ok;
        n_addr   = r_addr;
        n_cmd    = r_cmd;
        n_status = r_status;
        o_push   = 1'b0;

        o_event.addr        = r_addr;
        o_event.cmd         = r_cmd;
        o_event.status      = (r_pos == POS_STAT) ? b : r_status;
        o_event.len         = r_len;
        o_event.crc_ok      = r_low_ok && (b == r_tcrc[15:8]);
        o_event.short_frame = 1'b0;

        if (i_cfg.valid) begin
            n_sync = i_cfg.sync_byte;
        end

        if (accept) begin
            if (r_pos == POS_HUNT) begin
                if (b == r_sync) begin
                    n_hcrc   = crc8_step(CRC8_INIT, b);
                    n_tcrc   = crc16_step(CRC16_INIT, b);
                    n_low_ok = 1'b0;
                    n_addr   = '0;
                    n_cmd    = '0;
                    n_status = '0;
                    n_pos    = POS_ADDR;
                end
            end else if (r_pos < POS_HCRC) begin
                n_hcrc = crc8_step(r_hcrc, b);
                n_tcrc = crc16_step(r_tcrc, b);
                if (r_pos == POS_ADDR) begin
                    n_addr = b;
                end
                if (r_pos == POS_LEN) begin
                    n_len = b;
                end
                n_pos = r_pos + 8'd1;
            end else if (r_pos == POS_HCRC) begin
                if (b != r_hcrc || r_len > 8'(MAX_FRAME)) begin
                    n_pos = POS_HUNT;
                end else if (r_len < MIN_FRAME) begin
                    // short frame: verdict right after the header check
                    o_push              = 1'b1;
                    o_event.short_frame = 1'b1;
                    n_pos               = POS_HUNT;
                end else begin
                    n_tcrc = crc16_step(r_tcrc, b);
                    n_pos  = POS_CMD;
                end
            end else begin
                if (r_pos == POS_CMD) begin
                    n_cmd = b;
                end
                if (r_pos == POS_STAT) begin
                    n_status = b;
                end
                if (hit_low) begin
                    n_low_ok = (b == r_tcrc[7:0]);
                    n_pos    = r_pos + 8'd1;
                end else if (hit_last) begin
                    o_push = 1'b1;
                    n_pos  = POS_HUNT;
                end else begin
                    n_tcrc = crc16_step(r_tcrc, b);
                    n_pos  = r_pos + 8'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync <= SYNC_RESET;
            r_pos  <= POS_HUNT;
        end else begin
            r_sync <= n_sync;
            r_pos  <= n_pos;
        end
        r_len    <= n_len;
        r_hcrc   <= n_hcrc;
        r_tcrc   <= n_tcrc;
        r_low_ok <= n_low_ok;
        r_addr   <= n_addr;
        r_cmd    <= n_cmd;
        r_status <= n_status;
    end

endmodule

// File: design/crcfr_fifo.sv
module crcfr_fifo #(
    parameter int DEPTH = crcfr_pkg::FIFO_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  crcfr_pkg::t_event i_event,
    input  logic              i_pop,
    output logic              o_full,
    output logic              o_valid,
    output crcfr_pkg::t_event o_event
);
    import crcfr_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_event             r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr, n_wr;
    logic [PTR_W-1:0]   r_rd, n_rd;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic               do_push;
    logic               do_pop;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_event = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
        end
        if (do_pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
        if (do_push) begin
            r_mem[r_wr] <= i_event;
        end
    end

endmodule

// File: design/crcfr_back.sv
module crcfr_back #(
    parameter int NUM_SLOTS = crcfr_pkg::NUM_SLOTS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  crcfr_pkg::t_event i_event,
    output logic              o_pop,
    crcfr_res_if.source       o_res
);
    import crcfr_pkg::*;

    logic                  r_valid;
    logic [MASK_SLOTS-1:0] r_online, n_online;
    logic [MASK_SLOTS-1:0] r_waiting, n_waiting;
    t_event                r_ev;
    t_verdict              r_verdict, n_verdict;
    logic [MASK_SLOTS-1:0] bit_sel;
    logic                  in_range;

    assign o_pop    = i_valid && (!r_valid || o_res.ready);
    assign in_range = i_event.addr < 8'(NUM_SLOTS);
    assign bit_sel  = MASK_SLOTS'(1) << i_event.addr[3:0];

    always_comb begin
        n_online  = r_online;
        n_waiting = r_waiting;
        if (i_event.short_frame) begin
            n_verdict = VERDICT_SHORT;
        end else if (!i_event.crc_ok) begin
            n_verdict = VERDICT_CRC_BAD;
        end else if (!in_range) begin
            n_verdict = VERDICT_RANGE;
        end else begin
            n_verdict = VERDICT_OK;
            // slots past the mask width are accepted but not tracked
            if (i_event.cmd == CMD_STATUS && i_event.addr < 8'(MASK_SLOTS)) begin
                if (i_event.status == ST_ONLINE_WAIT) begin
                    n_online  = r_online | bit_sel;
                    n_waiting = r_waiting | bit_sel;
                end else if (i_event.status == ST_ONLINE) begin
                    n_online  = r_online | bit_sel;
                    n_waiting = r_waiting & ~bit_sel;
                end else if (i_event.status == ST_OFFLINE) begin
                    n_online  = r_online & ~bit_sel;
                    n_waiting = r_waiting & ~bit_sel;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_online  <= '0;
            r_waiting <= '0;
        end else begin
            if (o_pop) begin
                r_valid   <= 1'b1;
                r_online  <= n_online;
                r_waiting <= n_waiting;
            end else if (o_res.ready) begin
                r_valid <= 1'b0;
            end
        end
        if (o_pop) begin
            r_ev      <= i_event;
            r_verdict <= n_verdict;
        end
    end

    assign o_res.valid        = r_valid;
    assign o_res.slot_address = r_ev.addr;
    assign o_res.command_code = r_ev.cmd;
    assign o_res.status_code  = r_ev.status;
    assign o_res.frame_length = r_ev.len;
    assign o_res.verdict      = r_verdict;
    assign o_res.online_mask  = r_online;
    assign o_res.waiting_mask = r_waiting;

endmodule

// File: design/crcfr_checker.sv
module crcfr_checker #(
    parameter int NUM_SLOTS = crcfr_pkg::NUM_SLOTS_DEF
) (
    input logic         i_clk,
    input logic         i_rst_n,
    crcfr_res_if.source i_res
);
    import crcfr_pkg::*;

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_res.valid)
        else $error("result valid after reset");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res.valid && i_res.verdict == VERDICT_RANGE)
            |-> (i_res.slot_address >= 8'(NUM_SLOTS)))
        else $error("range verdict for an address in range");

    a_short: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res.valid && i_res.verdict == VERDICT_SHORT)
            |-> (i_res.frame_length < MIN_FRAME))
        else $error("short verdict for a long frame");

    a_wait_online: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res.valid |-> ((i_res.waiting_mask & ~i_res.online_mask) == '0))
        else $error("slot waiting but not online");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res.valid && !i_res.ready)
            |=> (i_res.valid && $stable(i_res.verdict) && $stable(i_res.online_mask)))
        else $error("stalled result changed");

endmodule

bind crc_checked_frame_receiver crcfr_checker #(
    .NUM_SLOTS (NUM_SLOTS)
) u_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_res   (o_res)
);
